@@ design/ifmt_pkg.sv @@
// Shared opcodes, character constants and digit helpers for the integer field formatter.
package ifmt_pkg;

  localparam int MAX_FIELD = 32;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 16;
  localparam int FW_W    = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int NDIG    = 16;
  localparam int NDIG_W  = 5;
  localparam int IN_TDATA_W = 40;

  // Conversion codes
  typedef enum logic [OP_W-1:0] {
    OP_DEC    = 3'd0,
    OP_UNS    = 3'd1,
    OP_HEX_LO = 3'd2,
    OP_HEX_UP = 3'd3,
    OP_BIN    = 3'd4,
    OP_PTR    = 3'd5,
    OP_CHAR   = 3'd6,
    OP_PCT    = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    RADIX_2  = 2'd0,
    RADIX_10 = 2'd1,
    RADIX_16 = 2'd2
  } radix_t;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_CASE_BIT = 8'h20;

  localparam logic [FW_W-1:0] PTR_DIGITS = 6'd4;
  localparam logic [FW_W-1:0] MAX_FIELD_V = FW_W'(MAX_FIELD);

  // Reciprocal of ten for 16-bit operands: q = (x * 52429) >> 19
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Map one digit value to its ASCII symbol
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_UPPER_A + CHAR_W'(d - 4'd10);
      if (lower) begin
        c = c | CH_CASE_BIT;
      end
    end
    return c;
  endfunction

endpackage

@@ design/integer_field_formatter_core.sv @@
// Integer field formatter: turns one conversion request into a stream of ASCII characters.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | tdata: request fields, tuser: opcode
//  out_    | out | out_tvalid/out_tready | tdata: character, tlast: final char, tuser: error
//
// A numeric request is accepted; the digit phase then takes one digit per cycle
// and ends with a closing check (only the check for a zero value), a sizing step
// follows, then one character is emitted per cycle while the output is free (up to
// MAX_FIELD + 1). Character, percent and error requests are accepted, then emit one beat.
// The digit unit (divide by ten through a reciprocal multiply, or a shift) sets the
// digit phase; the single output register sets the emit phase.
// Reset is synchronous and active low; it clears the sequencer and the output valid.
// A stalled output holds its beat; a new request is taken once the last character
// sits in the output register.
module integer_field_formatter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] value, [16] left_align, [17] force_plus, [18] space_sign, [19] zero_pad,
  // [25:20] field_width, [26] has_precision, [32:27] precision, [39:33] zero
  input  logic [ifmt_pkg::IN_TDATA_W-1:0] in_tdata,
  // [2:0] opcode
  input  logic [ifmt_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_char
  output logic [ifmt_pkg::CHAR_W-1:0]     out_tdata,
  output logic                            out_tlast,
  // [0] error
  output logic [0:0]                      out_tuser
);

  import ifmt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_SIZE,
    ST_EMIT,
    ST_ONE
  } state_t;

  state_t state_r;

  // Request fields
  logic [VALUE_W-1:0] in_value;
  logic               in_lalign, in_fplus, in_fspace, in_zpad, in_hasp;
  logic [FW_W-1:0]    in_fw, in_pr;
  opcode_t            in_op;

  assign in_value  = in_tdata[15:0];
  assign in_lalign = in_tdata[16];
  assign in_fplus  = in_tdata[17];
  assign in_fspace = in_tdata[18];
  assign in_zpad   = in_tdata[19];
  assign in_fw     = in_tdata[25:20];
  assign in_hasp   = in_tdata[26];
  assign in_pr     = in_tdata[32:27];
  assign in_op     = opcode_t'(in_tuser);

  // Working registers
  logic [VALUE_W-1:0] mag_r;
  radix_t             radix_r;
  logic               lower_r;
  logic               lalign_r, zpad_r;
  logic [FW_W-1:0]    fw_r, pr_r;
  logic               have_sign_r;
  logic [CHAR_W-1:0]  sign_char_r;
  logic [NDIG_W-1:0]  nd_r;
  logic [DIGIT_W-1:0] dig_r [NDIG];
  logic [FW_W-1:0]    lsp_r, pz_r, left_r;
  logic [CHAR_W-1:0]  char_r;
  logic               err_r;

  // Output register
  logic               out_tvalid_r;
  logic [CHAR_W-1:0]  out_tdata_r;
  logic               out_tlast_r;
  logic               out_tuser_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  logic in_fire, out_free, out_load;
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = out_free && ((state_r == ST_EMIT) || (state_r == ST_ONE));

  // Decode request at accept
  logic               req_err, req_single;
  logic [VALUE_W-1:0] req_neg;
  assign req_err    = (in_fw > MAX_FIELD_V) || (in_hasp && (in_pr > MAX_FIELD_V));
  assign req_single = req_err || (in_op == OP_CHAR) || (in_op == OP_PCT);
  assign req_neg    = VALUE_W'(~in_value + 16'd1);

  // Shared digit unit: one digit of mag_r per cycle
  logic [31:0]        div_prod;
  logic [12:0]        div_q;
  logic [VALUE_W-1:0] q10;
  logic [DIGIT_W-1:0] dig_val;
  logic [VALUE_W-1:0] mag_nxt;
  assign div_prod = mag_r * DIV10_MUL;
  assign div_q    = div_prod[31:DIV10_SHIFT];
  assign q10      = VALUE_W'({div_q, 3'b000}) + VALUE_W'({div_q, 1'b0});

  always_comb begin
    unique case (radix_r)
      RADIX_10: begin
        dig_val = DIGIT_W'(mag_r - q10);
        mag_nxt = VALUE_W'(div_q);
      end
      RADIX_2: begin
        dig_val = DIGIT_W'(mag_r[0]);
        mag_nxt = mag_r >> 1;
      end
      default: begin
        dig_val = mag_r[3:0];
        mag_nxt = mag_r >> 4;
      end
    endcase
  end

  // Field sizing from digit count, precision, sign and width
  logic [FW_W-1:0] nd_ext, numw, total0, pad, size_lsp, size_pz;
  assign nd_ext = FW_W'(nd_r);
  assign numw   = (nd_ext > pr_r) ? nd_ext : pr_r;
  assign total0 = numw + FW_W'(have_sign_r);
  assign pad    = (fw_r > total0) ? (fw_r - total0) : '0;

  always_comb begin
    size_lsp = lalign_r ? '0 : pad;
    size_pz  = numw - nd_ext;
    if (zpad_r) begin
      size_pz  = size_pz + size_lsp;
      size_lsp = '0;
    end
  end

  // Pick the next character: left spaces, sign, zeros, digits, right spaces
  logic [NDIG_W-1:0] nd_dec;
  logic [CHAR_W-1:0] emit_char;
  assign nd_dec = nd_r - 5'd1;

  always_comb begin
    priority if (lsp_r != '0) begin
      emit_char = CH_SPACE;
    end else if (have_sign_r) begin
      emit_char = sign_char_r;
    end else if (pz_r != '0) begin
      emit_char = CH_ZERO;
    end else if (nd_r != '0) begin
      emit_char = digit_char(dig_r[nd_dec[3:0]], lower_r);
    end else begin
      emit_char = CH_SPACE;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop a taken beat unless a new one loads below
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            lalign_r    <= in_lalign;
            lower_r     <= (in_op == OP_HEX_LO);
            nd_r        <= '0;
            err_r       <= req_err;
            char_r      <= req_err ? '0 : ((in_op == OP_PCT) ? CH_PCT : in_value[7:0]);
            have_sign_r <= 1'b0;
            sign_char_r <= CH_SPACE;
            mag_r       <= in_value;
            if (in_op == OP_PTR) begin
              fw_r   <= PTR_DIGITS;
              pr_r   <= PTR_DIGITS;
              zpad_r <= 1'b0;
            end else begin
              fw_r   <= in_fw;
              pr_r   <= in_hasp ? in_pr : 6'd1;
              zpad_r <= in_zpad && !in_hasp;
            end
            if (in_op == OP_DEC || in_op == OP_UNS) begin
              radix_r <= RADIX_10;
            end else if (in_op == OP_BIN) begin
              radix_r <= RADIX_2;
            end else begin
              radix_r <= RADIX_16;
            end
            if (in_op == OP_DEC) begin
              if (in_value[15]) begin
                mag_r       <= req_neg;
                have_sign_r <= 1'b1;
                sign_char_r <= CH_MINUS;
              end else if (in_fplus) begin
                have_sign_r <= 1'b1;
                sign_char_r <= CH_PLUS;
              end else if (in_fspace) begin
                have_sign_r <= 1'b1;
                sign_char_r <= CH_SPACE;
              end
            end
            state_r <= req_single ? ST_ONE : ST_DIGIT;
          end
        end

        ST_DIGIT: begin
          // Peel one digit per cycle, lowest first
          if (mag_r == '0) begin
            state_r <= ST_SIZE;
          end else begin
            dig_r[nd_r[3:0]] <= dig_val;
            mag_r            <= mag_nxt;
            nd_r             <= nd_r + 5'd1;
          end
        end

        ST_SIZE: begin
          lsp_r  <= size_lsp;
          pz_r   <= size_pz;
          left_r <= total0 + pad;
          state_r <= ((total0 + pad) == '0) ? ST_IDLE : ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= emit_char;
            out_tlast_r  <= (left_r == 6'd1);
            out_tuser_r  <= 1'b0;
            left_r       <= left_r - 6'd1;
            priority if (lsp_r != '0) begin
              lsp_r <= lsp_r - 6'd1;
            end else if (have_sign_r) begin
              have_sign_r <= 1'b0;
            end else if (pz_r != '0) begin
              pz_r <= pz_r - 6'd1;
            end else if (nd_r != '0) begin
              nd_r <= nd_dec;
            end else begin
              // right padding: counted by left_r alone
            end
            if (left_r == 6'd1) begin
              state_r <= ST_IDLE;
            end
          end
        end

        ST_ONE: begin
          // Character, percent or error: a single final beat
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= char_r;
            out_tlast_r  <= 1'b1;
            out_tuser_r  <= err_r;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
